// ===== rtl/aesc_pkg.sv =====
// Package for the AES ECB/CBC block: S-box tables, round helpers, register indexes.
// Used by aes_block_cipher_ecb_cbc; depends on nothing else.
package aesc_pkg;

	localparam int RK_DEPTH_DEF = 60;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_DATA_W = 64;

	localparam logic [CFG_IDX_W-1:0] REG_KEY_SIZE = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_CHAIN_MODE = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD0 = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_KEY_WORD3 = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_IV_HI = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_IV_LO = 4'd7;

	localparam logic ACT_ENCRYPT = 1'b0;

	typedef logic [127:0] blk_t;

	localparam logic [7:0] SBOX_FW [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	localparam logic [7:0] SBOX_INV [256] = '{
		8'h52,8'h09,8'h6a,8'hd5,8'h30,8'h36,8'ha5,8'h38,8'hbf,8'h40,8'ha3,8'h9e,8'h81,8'hf3,8'hd7,8'hfb,
		8'h7c,8'he3,8'h39,8'h82,8'h9b,8'h2f,8'hff,8'h87,8'h34,8'h8e,8'h43,8'h44,8'hc4,8'hde,8'he9,8'hcb,
		8'h54,8'h7b,8'h94,8'h32,8'ha6,8'hc2,8'h23,8'h3d,8'hee,8'h4c,8'h95,8'h0b,8'h42,8'hfa,8'hc3,8'h4e,
		8'h08,8'h2e,8'ha1,8'h66,8'h28,8'hd9,8'h24,8'hb2,8'h76,8'h5b,8'ha2,8'h49,8'h6d,8'h8b,8'hd1,8'h25,
		8'h72,8'hf8,8'hf6,8'h64,8'h86,8'h68,8'h98,8'h16,8'hd4,8'ha4,8'h5c,8'hcc,8'h5d,8'h65,8'hb6,8'h92,
		8'h6c,8'h70,8'h48,8'h50,8'hfd,8'hed,8'hb9,8'hda,8'h5e,8'h15,8'h46,8'h57,8'ha7,8'h8d,8'h9d,8'h84,
		8'h90,8'hd8,8'hab,8'h00,8'h8c,8'hbc,8'hd3,8'h0a,8'hf7,8'he4,8'h58,8'h05,8'hb8,8'hb3,8'h45,8'h06,
		8'hd0,8'h2c,8'h1e,8'h8f,8'hca,8'h3f,8'h0f,8'h02,8'hc1,8'haf,8'hbd,8'h03,8'h01,8'h13,8'h8a,8'h6b,
		8'h3a,8'h91,8'h11,8'h41,8'h4f,8'h67,8'hdc,8'hea,8'h97,8'hf2,8'hcf,8'hce,8'hf0,8'hb4,8'he6,8'h73,
		8'h96,8'hac,8'h74,8'h22,8'he7,8'had,8'h35,8'h85,8'he2,8'hf9,8'h37,8'he8,8'h1c,8'h75,8'hdf,8'h6e,
		8'h47,8'hf1,8'h1a,8'h71,8'h1d,8'h29,8'hc5,8'h89,8'h6f,8'hb7,8'h62,8'h0e,8'haa,8'h18,8'hbe,8'h1b,
		8'hfc,8'h56,8'h3e,8'h4b,8'hc6,8'hd2,8'h79,8'h20,8'h9a,8'hdb,8'hc0,8'hfe,8'h78,8'hcd,8'h5a,8'hf4,
		8'h1f,8'hdd,8'ha8,8'h33,8'h88,8'h07,8'hc7,8'h31,8'hb1,8'h12,8'h10,8'h59,8'h27,8'h80,8'hec,8'h5f,
		8'h60,8'h51,8'h7f,8'ha9,8'h19,8'hb5,8'h4a,8'h0d,8'h2d,8'he5,8'h7a,8'h9f,8'h93,8'hc9,8'h9c,8'hef,
		8'ha0,8'he0,8'h3b,8'h4d,8'hae,8'h2a,8'hf5,8'hb0,8'hc8,8'heb,8'hbb,8'h3c,8'h83,8'h53,8'h99,8'h61,
		8'h17,8'h2b,8'h04,8'h7e,8'hba,8'h77,8'hd6,8'h26,8'he1,8'h69,8'h14,8'h63,8'h55,8'h21,8'h0c,8'h7d
	};

	function automatic logic [7:0] xtime(input logic [7:0] b);
		return {b[6:0], 1'b0} ^ (b[7] ? 8'h1b : 8'h00);
	endfunction

	function automatic logic [31:0] sub_word(input logic [31:0] w);
		return {SBOX_FW[w[31:24]], SBOX_FW[w[23:16]], SBOX_FW[w[15:8]], SBOX_FW[w[7:0]]};
	endfunction

	// byte k of the block sits at bits 127-8k downto 120-8k
	function automatic blk_t sub_bytes(input blk_t s, input logic inv);
		blk_t t;
		for (int k = 0; k < 16; k++) begin
			t[127-8*k -: 8] = inv ? SBOX_INV[s[127-8*k -: 8]] : SBOX_FW[s[127-8*k -: 8]];
		end
		return t;
	endfunction

	function automatic blk_t shift_rows(input blk_t s, input logic inv);
		blk_t t;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				if (inv) begin
					t[127-8*(4*((c+r)%4)+r) -: 8] = s[127-8*(4*c+r) -: 8];
				end else begin
					t[127-8*(4*c+r) -: 8] = s[127-8*(4*((c+r)%4)+r) -: 8];
				end
			end
		end
		return t;
	endfunction

	function automatic blk_t mix_columns(input blk_t s, input logic inv);
		blk_t t;
		logic [7:0] a [4];
		logic [7:0] a2 [4];
		logic [7:0] a4 [4];
		logic [7:0] a8 [4];
		logic [7:0] m1 [4];
		logic [7:0] m2 [4];
		logic [7:0] m3 [4];
		logic [7:0] m0 [4];
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				a[r] = s[127-8*(4*c+r) -: 8];
				a2[r] = xtime(a[r]);
				a4[r] = xtime(a2[r]);
				a8[r] = xtime(a4[r]);
				// times 2/14, 3/11, 1/13, 1/9
				m0[r] = inv ? (a8[r] ^ a4[r] ^ a2[r]) : a2[r];
				m1[r] = inv ? (a8[r] ^ a2[r] ^ a[r]) : (a2[r] ^ a[r]);
				m2[r] = inv ? (a8[r] ^ a4[r] ^ a[r]) : a[r];
				m3[r] = inv ? (a8[r] ^ a[r]) : a[r];
			end
			for (int r = 0; r < 4; r++) begin
				t[127-8*(4*c+r) -: 8] = m0[r] ^ m1[(r+1)%4] ^ m2[(r+2)%4] ^ m3[(r+3)%4];
			end
		end
		return t;
	endfunction

endpackage

// ===== rtl/aes_block_cipher_ecb_cbc.sv =====
// AES-128/192/256 block cipher, ECB or CBC, one round per cycle unless the output stalls.
// Each accepted block runs the initial key addition, then nr rounds (nr = 10, 12 or 14);
// one block at a time, a new block is taken once the previous one has left the round loop
// and no key expansion is running; the last round waits while the previous result is untaken.
// A key or key-size write starts an expansion of nr*4+4 key words, one key word per cycle.
// Reset clears control, registers and chaining value; the round-key memory is not cleared.
module aes_block_cipher_ecb_cbc #(
	parameter int ROUND_KEY_DEPTH = aesc_pkg::RK_DEPTH_DEF
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [aesc_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [aesc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic in_valid,
	output logic in_ready,
	input  logic action,
	input  logic [63:0] block_hi,
	input  logic [63:0] block_lo,
	output logic out_valid,
	input  logic out_ready,
	output logic [63:0] result_hi,
	output logic [63:0] result_lo
);
	import aesc_pkg::*;

	localparam int RK_ROWS = (ROUND_KEY_DEPTH + 3) / 4;
	localparam int RW = $clog2(RK_ROWS);
	localparam int IW = $clog2(ROUND_KEY_DEPTH);
	localparam logic [1:0] MAX_SEL = (ROUND_KEY_DEPTH >= 60) ? 2'd2 :
		(ROUND_KEY_DEPTH >= 52) ? 2'd1 : 2'd0;

	logic [1:0] key_size_q;
	logic chain_mode_q;
	logic [63:0] key_word_q [4];
	logic [63:0] iv_hi_q, iv_lo_q;
	blk_t chain_q;

	blk_t rk_mem [RK_ROWS];
	blk_t rk_row_q;

	// effective key size and derived counts
	logic [1:0] sel;
	logic [3:0] nr, nk;
	logic [IW-1:0] last_word;
	always_comb begin
		sel = (key_size_q > 2'd2) ? 2'd2 : key_size_q;
		if (sel > MAX_SEL) begin
			sel = MAX_SEL;
		end
		nr = 4'd10 + {1'b0, sel, 1'b0};
		nk = 4'd4 + {1'b0, sel, 1'b0};
		last_word = IW'({nr, 2'b11});
	end

	// key expansion sequencer
	logic exp_q;
	logic [IW-1:0] wi_q;
	logic [3:0] pos_q;
	logic [7:0] rcon_q;
	logic [31:0] win_q [8];
	logic [31:0] kw_new, kw_tmp;
	logic [63:0] kw_src;
	logic key_wr;

	assign key_wr = cfg_we && (cfg_index == REG_KEY_SIZE ||
		(cfg_index >= REG_KEY_WORD0 && cfg_index <= REG_KEY_WORD3));

	always_comb begin
		kw_src = key_word_q[wi_q[2:1]];
		kw_tmp = win_q[0];
		if (pos_q == 4'd0) begin
			kw_tmp = sub_word({win_q[0][23:0], win_q[0][31:24]}) ^ {rcon_q, 24'h0};
		end else if (nk == 4'd8 && pos_q == 4'd4) begin
			kw_tmp = sub_word(win_q[0]);
		end
		if (wi_q < IW'(nk)) begin
			kw_new = wi_q[0] ? kw_src[31:0] : kw_src[63:32];
		end else begin
			kw_new = kw_tmp ^ win_q[nk[2:0] - 3'd1];
		end
	end

	// round engine
	logic busy_q;
	logic [3:0] step_q;
	logic act_q, cbc_q;
	blk_t st_q, blk_q;
	blk_t st_next, res_blk, x;
	logic accept, first, last, advance, rd_en;
	logic [3:0] rd_row;
	logic out_valid_q;
	logic [63:0] res_hi_q, res_lo_q;

	assign in_ready = !busy_q && !exp_q;
	assign accept = in_valid && in_ready;
	assign first = step_q == 4'd0;
	assign last = step_q == nr;
	assign advance = busy_q && !(last && out_valid_q && !out_ready);
	assign rd_en = accept || advance;

	always_comb begin
		if (accept) begin
			rd_row = (action == ACT_ENCRYPT) ? 4'd0 : nr;
		end else begin
			rd_row = (act_q == ACT_ENCRYPT) ? step_q + 4'd1 : nr - step_q - 4'd1;
		end
	end

	always_comb begin
		x = st_q ^ rk_row_q;
		if (act_q == ACT_ENCRYPT) begin
			if (first) begin
				st_next = st_q ^ rk_row_q;
			end else begin
				x = shift_rows(sub_bytes(st_q, 1'b0), 1'b0);
				st_next = (last ? x : mix_columns(x, 1'b0)) ^ rk_row_q;
			end
			res_blk = st_next;
		end else begin
			if (last) begin
				st_next = x;
			end else if (first) begin
				st_next = sub_bytes(shift_rows(x, 1'b1), 1'b1);
			end else begin
				st_next = sub_bytes(shift_rows(mix_columns(x, 1'b1), 1'b1), 1'b1);
			end
			res_blk = cbc_q ? (st_next ^ chain_q) : st_next;
		end
	end

	// round-key memory: one 128-bit row per round, written a word at a time
	always_ff @(posedge clk) begin
		if (exp_q) begin
			rk_mem[RW'(wi_q >> 2)][(3 - int'(wi_q[1:0]))*32 +: 32] <= kw_new;
		end
		if (rd_en) begin
			rk_row_q <= rk_mem[rd_row[RW-1:0]];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_size_q <= '0;
			chain_mode_q <= 1'b0;
			for (int k = 0; k < 4; k++) begin
				key_word_q[k] <= '0;
			end
			iv_hi_q <= '0;
			iv_lo_q <= '0;
			chain_q <= '0;
			exp_q <= 1'b0;
			wi_q <= '0;
			pos_q <= '0;
			rcon_q <= 8'h01;
			busy_q <= 1'b0;
			step_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_KEY_SIZE: key_size_q <= cfg_data[1:0];
					REG_CHAIN_MODE: chain_mode_q <= cfg_data[0];
					REG_IV_HI: begin
						iv_hi_q <= cfg_data;
						chain_q <= {cfg_data, iv_lo_q};
					end
					REG_IV_LO: begin
						iv_lo_q <= cfg_data;
						chain_q <= {iv_hi_q, cfg_data};
					end
					default: begin
						if (key_wr) begin
							key_word_q[2'(cfg_index - REG_KEY_WORD0)] <= cfg_data;
						end
					end
				endcase
			end

			// a key write restarts expansion from word zero
			if (key_wr) begin
				exp_q <= 1'b1;
				wi_q <= '0;
				pos_q <= '0;
				rcon_q <= 8'h01;
			end else if (exp_q) begin
				if (wi_q == last_word) begin
					exp_q <= 1'b0;
				end
				wi_q <= wi_q + 1'b1;
				pos_q <= (pos_q == nk - 4'd1) ? 4'd0 : pos_q + 4'd1;
				if (pos_q == 4'd0 && wi_q >= IW'(nk)) begin
					rcon_q <= xtime(rcon_q);
				end
			end

			if (out_valid_q && out_ready) begin
				out_valid_q <= 1'b0;
			end
			if (accept) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (advance) begin
				step_q <= step_q + 4'd1;
				if (last) begin
					busy_q <= 1'b0;
					out_valid_q <= 1'b1;
					if (cbc_q) begin
						chain_q <= (act_q == ACT_ENCRYPT) ? st_next : blk_q;
					end
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (exp_q) begin
			win_q[0] <= kw_new;
			for (int k = 1; k < 8; k++) begin
				win_q[k] <= win_q[k-1];
			end
		end
		if (accept) begin
			act_q <= action;
			cbc_q <= chain_mode_q;
			blk_q <= {block_hi, block_lo};
			st_q <= (chain_mode_q && action == ACT_ENCRYPT) ?
				({block_hi, block_lo} ^ chain_q) : {block_hi, block_lo};
		end else if (advance) begin
			st_q <= st_next;
			if (last) begin
				res_hi_q <= res_blk[127:64];
				res_lo_q <= res_blk[63:0];
			end
		end
	end

	assign out_valid = out_valid_q;
	assign result_hi = res_hi_q;
	assign result_lo = res_lo_q;

endmodule
